>>> hdl/gradient_palette_blend_sampler_defines.svh
// Assertion macros shared by the gradient palette blend sampler RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef GRADIENT_PALETTE_BLEND_SAMPLER_DEFINES_SVH
`define GRADIENT_PALETTE_BLEND_SAMPLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GPBS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GPBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/gpbs_pkg.sv
// Shared types and constants of the gradient palette blend sampler.
// No dependencies; every module of the block imports it.
package gpbs_pkg;

    localparam int CHAN_W        = 8;
    localparam int POS_W         = 8;
    localparam int NUM_CH        = 3;
    localparam int STOP_W        = 32;
    localparam int NUM_STOP_REGS = 4;
    localparam int CNT_W         = 3;
    localparam int MAX_STOPS_DEF = 4;

    // Configuration port
    localparam int DATA_W = 64;
    localparam int ADDR_W = 6;
    localparam int IDX_W  = 3;
    localparam logic [IDX_W-1:0] REG_A_LO  = 3'd0;
    localparam logic [IDX_W-1:0] REG_A_HI  = 3'd1;
    localparam logic [IDX_W-1:0] REG_B_LO  = 3'd2;
    localparam logic [IDX_W-1:0] REG_B_HI  = 3'd3;
    localparam logic [IDX_W-1:0] REG_A_CNT = 3'd4;
    localparam logic [IDX_W-1:0] REG_B_CNT = 3'd5;

    // Divider: 8-bit quotient, two quotient bits per cycle
    localparam int QUO_W     = CHAN_W;
    localparam int DEN_W     = CHAN_W + 1;
    localparam int NUM_W     = 2 * CHAN_W + 1;
    localparam int PROD_W    = 2 * CHAN_W;
    localparam int DSH_W     = DEN_W + QUO_W - 1;
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = QUO_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

    typedef logic [NUM_CH-1:0][CHAN_W-1:0] rgb_t;
    typedef logic [NUM_CH-1:0][NUM_W-1:0]  num_arr_t;
    typedef logic [NUM_STOP_REGS-1:0][STOP_W-1:0] stop_arr_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [CHAN_W-1:0] mix;
    } req_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rsp_item_t;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_M
    } phase_t;

    typedef struct packed {
        logic   accept;
        logic   op_load;
        phase_t op_sel;
        logic   div_start;
        logic   cap_a;
        logic   cap_b;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic out_free;
    } dp_sts_t;

endpackage

>>> hdl/gpbs_div.sv
// Three-lane restoring divider, two quotient bits per cycle, shared divisor.
// Depends on gpbs_pkg and the assertion macro header.
`include "gradient_palette_blend_sampler_defines.svh"

module gpbs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  gpbs_pkg::num_arr_t            num,
    input  logic [gpbs_pkg::DEN_W-1:0]    den,
    output logic                          busy,
    output logic                          done,
    output gpbs_pkg::rgb_t                quo
);
    import gpbs_pkg::*;

    num_arr_t           rem_reg, rem_next;
    rgb_t               quo_reg, quo_next;
    logic [DSH_W-1:0]   dsh_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;

    // Quotient fits in QUO_W bits, so start with the divisor at the top bit
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            rem_next[ch] = rem_reg[ch];
            quo_next[ch] = quo_reg[ch];
            for (int s = 0; s < DIV_BITS; s++)
            begin
                if (rem_next[ch] >= NUM_W'(dsh_reg >> s))
                begin
                    rem_next[ch] = rem_next[ch] - NUM_W'(dsh_reg >> s);
                    quo_next[ch] = {quo_next[ch][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next[ch] = {quo_next[ch][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            quo_reg <= '0;
            dsh_reg <= DSH_W'(den) << (QUO_W - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dsh_reg <= dsh_reg >> DIV_BITS;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

    `GPBS_ASSERT_NEXT(a_start_runs, start, busy_reg && !done_reg, "divider did not start")
    `GPBS_ASSERT_NEXT(a_last_step_done, busy_reg && !start && step_reg == STEP_W'(DIV_STEPS - 1), done_reg && !busy_reg, "divider missed its last step")
    `GPBS_ASSERT_IMPL(a_done_not_busy, done_reg, !busy_reg, "divider done while busy")

endmodule

>>> hdl/gpbs_dp.sv
// Datapath: input and operand registers, palette stop selection, dividend setup,
// the shared divider and the output register. Depends on gpbs_pkg and gpbs_div.
module gpbs_dp #(
    parameter int MAX_STOPS = gpbs_pkg::MAX_STOPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gpbs_pkg::dp_cmd_t             cmd,
    output gpbs_pkg::dp_sts_t             sts,
    input  gpbs_pkg::req_item_t           req_item,
    input  gpbs_pkg::stop_arr_t           stops_a,
    input  gpbs_pkg::stop_arr_t           stops_b,
    input  logic [gpbs_pkg::CNT_W-1:0]    count_a,
    input  logic [gpbs_pkg::CNT_W-1:0]    count_b,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output gpbs_pkg::rsp_item_t           rsp_item
);
    import gpbs_pkg::*;

    // One interpolation: left/right colors weighted by (span - offset) and offset
    typedef struct packed {
        rgb_t              left;
        rgb_t              right;
        logic [POS_W-1:0]  span;
        logic [POS_W-1:0]  offset;
    } op_t;

    function automatic rgb_t stop_rgb(input logic [STOP_W-1:0] w);
        rgb_t c;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            c[ch] = w[CHAN_W*(ch+1) +: CHAN_W];
        end
        return c;
    endfunction

    // A plain color goes through the divider as (2c + 1) / 2
    function automatic op_t copy_op(input rgb_t c);
        op_t op;
        op.left   = c;
        op.right  = c;
        op.span   = POS_W'(1);
        op.offset = '0;
        return op;
    endfunction

    function automatic op_t plan_sample(
        input stop_arr_t         st,
        input logic [CNT_W-1:0]  cnt,
        input logic [POS_W-1:0]  u
    );
        logic [CNT_W-1:0]  n;
        logic [STOP_W-1:0] last;
        logic [POS_W-1:0]  pa;
        logic [POS_W-1:0]  pb;
        logic              hit;
        op_t               op;
        n    = (cnt > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : cnt;
        last = st[0];
        for (int k = 0; k < MAX_STOPS; k++)
        begin
            if (CNT_W'(k + 1) == n)
            begin
                last = st[k];
            end
        end
        // Unsorted stops with no matching interval fall back to the last stop
        op  = copy_op(stop_rgb(last));
        hit = 1'b0;
        for (int i = 0; i < MAX_STOPS - 1; i++)
        begin
            pa = st[i][POS_W-1:0];
            pb = st[i+1][POS_W-1:0];
            if (!hit && CNT_W'(i + 1) < n && u >= pa && u <= pb)
            begin
                hit = 1'b1;
                if (pa == pb)
                begin
                    op = copy_op(stop_rgb(st[i]));
                end
                else
                begin
                    op.left   = stop_rgb(st[i]);
                    op.right  = stop_rgb(st[i+1]);
                    op.span   = pb - pa;
                    op.offset = u - pa;
                end
            end
        end
        if (u >= last[POS_W-1:0])
        begin
            op = copy_op(stop_rgb(last));
        end
        if (n == CNT_W'(1) || u <= st[0][POS_W-1:0])
        begin
            op = copy_op(stop_rgb(st[0]));
        end
        if (n == '0)
        begin
            op = copy_op('0);
        end
        return op;
    endfunction

    req_item_t                       item_reg;
    op_t                             op_reg;
    op_t                             op_next;
    rgb_t                            samp_a_reg;
    rgb_t                            samp_b_reg;
    rsp_item_t                       out_reg;
    logic                            out_valid_reg;
    logic [CHAN_W-1:0]               mix_eff;
    logic [NUM_CH-1:0][PROD_W-1:0]   prod_l;
    logic [NUM_CH-1:0][PROD_W-1:0]   prod_r;
    logic [NUM_CH-1:0][PROD_W-1:0]   psum;
    num_arr_t                        div_num;
    logic [DEN_W-1:0]                div_den;
    logic                            div_busy;
    logic                            div_done;
    rgb_t                            div_quo;

    // Absent palettes force the blend weight to one end
    always_comb
    begin
        priority if (count_b == '0)
        begin
            mix_eff = '0;
        end
        else if (count_a == '0 && item_reg.mix != '0)
        begin
            mix_eff = FULL_SCALE;
        end
        else
        begin
            mix_eff = item_reg.mix;
        end
    end

    always_comb
    begin
        unique case (cmd.op_sel)
            PH_A:
            begin
                op_next = plan_sample(stops_a, count_a, item_reg.position);
            end
            PH_B:
            begin
                op_next = plan_sample(stops_b, count_b, item_reg.position);
            end
            PH_M:
            begin
                op_next.left   = samp_a_reg;
                op_next.right  = samp_b_reg;
                op_next.span   = FULL_SCALE;
                op_next.offset = mix_eff;
            end
            default:
            begin
                op_next = copy_op('0);
            end
        endcase
    end

    // Dividend 2*(l*(span-offset) + r*offset) + span, divisor 2*span: rounds half up
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            prod_l[ch]  = PROD_W'(op_reg.left[ch]) * PROD_W'(op_reg.span - op_reg.offset);
            prod_r[ch]  = PROD_W'(op_reg.right[ch]) * PROD_W'(op_reg.offset);
            psum[ch]    = prod_l[ch] + prod_r[ch];
            div_num[ch] = NUM_W'({psum[ch], 1'b0}) + NUM_W'(op_reg.span);
        end
    end

    assign div_den = {op_reg.span, 1'b0};

    gpbs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= req_item;
        end
        if (cmd.op_load)
        begin
            op_reg <= op_next;
        end
        if (cmd.cap_a)
        begin
            samp_a_reg <= div_quo;
        end
        if (cmd.cap_b)
        begin
            samp_b_reg <= div_quo;
        end
        if (cmd.out_load)
        begin
            out_reg.red   <= div_quo[0];
            out_reg.green <= div_quo[1];
            out_reg.blue  <= div_quo[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || !rsp_stall;
    assign rsp_valid    = out_valid_reg;
    assign rsp_item     = out_reg;

endmodule

>>> hdl/gpbs_ctrl.sv
// Sequencer: runs palette A, palette B and the blend through the shared divider.
// Depends on gpbs_pkg and the assertion macro header.
`include "gradient_palette_blend_sampler_defines.svh"

module gpbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    output gpbs_pkg::dp_cmd_t    cmd,
    input  gpbs_pkg::dp_sts_t    sts
);
    import gpbs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLAN,
        ST_START,
        ST_WAIT
    } state_t;

    state_t state_reg;
    phase_t phase_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.op_sel = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = req_valid;
            end
            ST_PLAN:
            begin
                cmd.op_load = 1'b1;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
            end
            ST_WAIT:
            begin
                if (sts.div_done)
                begin
                    unique case (phase_reg)
                        PH_A:    cmd.cap_a    = 1'b1;
                        PH_B:    cmd.cap_b    = 1'b1;
                        PH_M:    cmd.out_load = sts.out_free;
                        default: cmd.cap_a    = 1'b0;
                    endcase
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_A;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= ST_PLAN;
                        phase_reg <= PH_A;
                    end
                end
                ST_PLAN:
                begin
                    state_reg <= ST_START;
                end
                ST_START:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (sts.div_done)
                    begin
                        unique case (phase_reg)
                            PH_A:
                            begin
                                state_reg <= ST_PLAN;
                                phase_reg <= PH_B;
                            end
                            PH_B:
                            begin
                                state_reg <= ST_PLAN;
                                phase_reg <= PH_M;
                            end
                            PH_M:
                            begin
                                // Hold the result in the divider until the output frees
                                if (sts.out_free)
                                begin
                                    state_reg <= ST_IDLE;
                                    phase_reg <= PH_A;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                                phase_reg <= PH_A;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

    `GPBS_ASSERT_IMPL(a_start_when_free, cmd.div_start, !sts.div_busy, "divider restarted while busy")
    `GPBS_ASSERT_IMPL(a_load_when_free, cmd.out_load, sts.out_free, "output overwritten while stalled")
    `GPBS_ASSERT_NEXT(a_accept_starts_a, cmd.accept, state_reg == ST_PLAN && phase_reg == PH_A, "accepted transaction did not start palette A")

endmodule

>>> hdl/gradient_palette_blend_sampler.sv
// Top level of the gradient palette blend sampler: configuration registers,
// APB-style port, sequencer and datapath. Depends on gpbs_pkg, gpbs_ctrl, gpbs_dp.
//
// Each request transaction carries a position and a mix weight (255 = 1.0) and
// yields one RGB response transaction. Palettes A and B each hold up to MAX_STOPS
// stops set through the register port (64-bit data, register i at byte 8*i: stop
// words for A, stop words for B, then the A and B stop counts; writes above index
// 5 are dropped). A palette with no stops is black, with one stop gives that stop,
// otherwise clamps to its end stops or interpolates in the first interval that
// holds the position; equal stop positions give the left stop, unsorted stops
// the last. An absent B gives A; otherwise mix 0 gives A, and mix 255 or an
// absent A with a nonzero mix gives B; both absent give black. All rounding is
// half up. A transaction makes three passes (sample A, sample B, blend) through
// the shared three-lane divider, which retires two quotient bits per cycle.
// The request side stalls while an item is in flight; a finished response may
// wait in the output register while the next request is already being worked on.
// Write configuration only when no transaction is in flight.
module gradient_palette_blend_sampler #(
    parameter int MAX_STOPS = gpbs_pkg::MAX_STOPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request channel
    input  logic                           req_valid,
    output logic                           req_stall,
    input  gpbs_pkg::req_item_t            req_item,
    // Response channel
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output gpbs_pkg::rsp_item_t            rsp_item,
    // Register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gpbs_pkg::ADDR_W-1:0]    paddr,
    input  logic [gpbs_pkg::DATA_W-1:0]    pwdata,
    output logic [gpbs_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import gpbs_pkg::*;

    logic [DATA_W-1:0] a_lo_reg;
    logic [DATA_W-1:0] a_hi_reg;
    logic [DATA_W-1:0] b_lo_reg;
    logic [DATA_W-1:0] b_hi_reg;
    logic [CNT_W-1:0]  a_cnt_reg;
    logic [CNT_W-1:0]  b_cnt_reg;
    logic              reg_wr;
    logic [IDX_W-1:0]  reg_idx;
    dp_cmd_t           cmd;
    dp_sts_t           sts;

    // Registers are 64 bits wide at 8-byte spacing; drop the byte offset
    assign reg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign reg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_lo_reg  <= '0;
            a_hi_reg  <= '0;
            b_lo_reg  <= '0;
            b_hi_reg  <= '0;
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
        end
        else if (reg_wr)
        begin
            unique case (reg_idx)
                REG_A_LO:  a_lo_reg  <= pwdata;
                REG_A_HI:  a_hi_reg  <= pwdata;
                REG_B_LO:  b_lo_reg  <= pwdata;
                REG_B_HI:  b_hi_reg  <= pwdata;
                REG_A_CNT: a_cnt_reg <= pwdata[CNT_W-1:0];
                REG_B_CNT: b_cnt_reg <= pwdata[CNT_W-1:0];
                default:   a_cnt_reg <= a_cnt_reg;
            endcase
        end
    end

    // Read back; unmapped addresses read zero
    always_comb
    begin
        unique case (reg_idx)
            REG_A_LO:  prdata = a_lo_reg;
            REG_A_HI:  prdata = a_hi_reg;
            REG_B_LO:  prdata = b_lo_reg;
            REG_B_HI:  prdata = b_hi_reg;
            REG_A_CNT: prdata = DATA_W'(a_cnt_reg);
            REG_B_CNT: prdata = DATA_W'(b_cnt_reg);
            default:   prdata = '0;
        endcase
    end

    gpbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Stop word k sits at bits 32k+31:32k of {high, low}
    gpbs_dp #(
        .MAX_STOPS (MAX_STOPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_item  (req_item),
        .stops_a   (stop_arr_t'({a_hi_reg, a_lo_reg})),
        .stops_b   (stop_arr_t'({b_hi_reg, b_lo_reg})),
        .count_a   (a_cnt_reg),
        .count_b   (b_cnt_reg),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule
